@@ rtl/smo_pkg.sv @@
// ============================================================================
// smo_pkg
// Shared types and constants for the stack with middle operations.
// ============================================================================
`default_nettype none

package smo_pkg;

    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_WORD_BITS   = 32;
    localparam int VALUE_BITS      = 32;
    localparam int MODE_BITS       = 3;
    localparam int STATUS_BITS     = 2;

    // Command codes carried in the mode field
    typedef enum logic [MODE_BITS-1:0] {
        MODE_PUSH     = 3'd0,
        MODE_POP      = 3'd1,
        MODE_PEEK     = 3'd2,
        MODE_FIND_MID = 3'd3,
        MODE_DEL_MID  = 3'd4
    } mode_t;

    // Response status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_DEL_MID
    } cell_op_t;

endpackage

`default_nettype wire

@@ rtl/smo_in_if.sv @@
// ============================================================================
// smo_in_if
// Command channel: valid/ready handshake with mode and push value.
// ============================================================================
`default_nettype none

interface smo_in_if
    import smo_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic [MODE_BITS-1:0]         mode;
    logic signed [VALUE_BITS-1:0] push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink   (input valid, input mode, input push_value, output ready);
endinterface

`default_nettype wire

@@ rtl/smo_out_if.sv @@
// ============================================================================
// smo_out_if
// Response channel: valid/ready handshake with read value, status and count.
// ============================================================================
`default_nettype none

interface smo_out_if
    import smo_pkg::*;
#(
    parameter int CNT_W = $clog2(DEF_STACK_DEPTH + 1)
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] read_value;
    logic [STATUS_BITS-1:0]       status;
    logic [CNT_W-1:0]             fill_count;

    modport source (output valid, output read_value, output status, output fill_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input fill_count,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/smo_cell.sv @@
// ============================================================================
// smo_cell
// One stack slot. Takes from the slot above or below, or holds, per command.
// ============================================================================
`default_nettype none

module smo_cell
    import smo_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int IDX_W     = 4,
    parameter int CELL_IDX  = 0
) (
    input  wire logic                 clk,
    input  wire cell_op_t             op,
    input  wire logic [IDX_W-1:0]     mid_idx,
    input  wire logic [WORD_BITS-1:0] prev_word,
    input  wire logic [WORD_BITS-1:0] next_word,
    output logic      [WORD_BITS-1:0] word,
    output logic      [WORD_BITS-1:0] mid_word
);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic                 at_mid;
    logic                 past_mid;

    assign at_mid   = (mid_idx == IDX_W'(CELL_IDX));
    assign past_mid = (IDX_W'(CELL_IDX) >= mid_idx);

    always_comb
    begin
        case (op)
            CELL_PUSH:    word_next = prev_word;
            CELL_POP:     word_next = next_word;
            CELL_DEL_MID: word_next = past_mid ? next_word : word_reg;
            default:      word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    assign mid_word = at_mid ? word_reg : '0;

endmodule

`default_nettype wire

@@ rtl/stack_with_middle_ops.sv @@
// ============================================================================
// stack_with_middle_ops
// Bounded LIFO stack with push, pop, peek, find middle and delete middle.
// ============================================================================
// Usage:
//   cmd carries one command per transaction (mode, push_value); rsp returns
//   one transaction per command (read_value, status, fill_count).
//   The stack is a chain of cells with the top of stack always in cell 0.
//   Push shifts every cell down by one, pop shifts every cell up by one, and
//   delete middle shifts up only the cells from the middle downwards. The
//   response is registered and appears in the cycle after the command is
//   accepted. The block takes one command per cycle while rsp does not
//   stall, with one shift of the cell chain per accepted command.
//   The middle word is picked by a one-hot compare in each cell and an OR
//   across the chain.
//   Reset clears the entry count and the response valid; cell contents are
//   not cleared, since no cell is read before it has been written.
//   When rsp stalls, the pending response holds and cmd ready drops until
//   the response is taken; a new command is accepted in the same cycle that
//   the pending response leaves.
// ============================================================================
`default_nettype none

module stack_with_middle_ops
    import smo_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int WORD_BITS   = DEF_WORD_BITS,
    parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic clk,
    input  wire logic rst_n,
    smo_in_if.sink    cmd,
    smo_out_if.source rsp
);

    localparam int IDX_W = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

    // Cell chain
    logic [WORD_BITS-1:0] word_arr [STACK_DEPTH];
    logic [WORD_BITS-1:0] mid_arr  [STACK_DEPTH];
    logic [WORD_BITS-1:0] push_word;
    logic [WORD_BITS-1:0] mid_sel;
    logic [IDX_W-1:0]     mid_idx;
    cell_op_t             cell_op;

    // Control and response registers
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] read_reg;
    logic [VALUE_BITS-1:0] read_next;
    status_t               status_reg;
    status_t               status_next;
    logic [CNT_W-1:0]      fill_reg;
    cell_op_t              op_next;

    logic                  take;
    logic                  is_empty;
    logic                  is_full;
    logic [VALUE_BITS-1:0] push_bits;

    assign take     = cmd.valid && cmd.ready;
    assign is_empty = (cnt_reg == '0);
    assign is_full  = (cnt_reg == CNT_W'(STACK_DEPTH));

    // Top-relative index of the middle entry: floor(count/2)
    assign mid_idx  = IDX_W'(cnt_reg >> 1);

    // Keep the low word bits of the pushed value, zero-extended if wider
    assign push_bits = cmd.push_value;
    assign push_word = WORD_BITS'(push_bits);

    generate
        for (genvar i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            logic [WORD_BITS-1:0] prev_w;
            logic [WORD_BITS-1:0] next_w;

            if (i == 0)
            begin : g_top
                assign prev_w = push_word;
            end
            else
            begin : g_inner_prev
                assign prev_w = word_arr[i-1];
            end

            if (i == STACK_DEPTH - 1)
            begin : g_bottom
                assign next_w = word_arr[i];
            end
            else
            begin : g_inner_next
                assign next_w = word_arr[i+1];
            end

            smo_cell #(
                .WORD_BITS (WORD_BITS),
                .IDX_W     (IDX_W),
                .CELL_IDX  (i)
            ) u_cell (
                .clk       (clk),
                .op        (cell_op),
                .mid_idx   (mid_idx),
                .prev_word (prev_w),
                .next_word (next_w),
                .word      (word_arr[i]),
                .mid_word  (mid_arr[i])
            );
        end
    endgenerate

    // Gather the middle word: exactly one cell contributes
    always_comb
    begin
        mid_sel = '0;
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            mid_sel = mid_sel | mid_arr[i];
        end
    end

    // Command decode
    always_comb
    begin
        op_next     = CELL_HOLD;
        read_next   = '0;
        status_next = ST_OK;
        cnt_next    = cnt_reg;
        unique case (cmd.mode) inside
            MODE_PUSH:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    op_next  = CELL_PUSH;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            MODE_POP, MODE_PEEK:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    read_next = VALUE_BITS'(word_arr[0]);
                    if (cmd.mode == MODE_POP)
                    begin
                        op_next  = CELL_POP;
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
            end
            MODE_FIND_MID, MODE_DEL_MID:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    read_next = VALUE_BITS'(mid_sel);
                    if (cmd.mode == MODE_DEL_MID)
                    begin
                        op_next  = CELL_DEL_MID;
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                // unused codes: report the current count and change nothing
                op_next = CELL_HOLD;
            end
        endcase
    end

    // Drive the chain only on an accepted transaction
    assign cell_op = take ? op_next : CELL_HOLD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            read_reg   <= read_next;
            status_reg <= status_next;
            fill_reg   <= cnt_next;
        end
    end

    assign cmd.ready      = !out_valid_reg || rsp.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = read_reg;
    assign rsp.status     = status_reg;
    assign rsp.fill_count = fill_reg;

endmodule

`default_nettype wire

@@ rtl/smo_checker.sv @@
// ============================================================================
// smo_checker
// Port-level checks on the stack responses, bound to the top level.
// ============================================================================
`default_nettype none

module smo_checker
    import smo_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   rsp_valid,
    input wire logic                   rsp_ready,
    input wire logic [VALUE_BITS-1:0]  rsp_read_value,
    input wire logic [STATUS_BITS-1:0] rsp_status,
    input wire logic [CNT_W-1:0]       rsp_fill_count
);

    // A stalled response holds its count
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fill_count))
        else $error("response dropped or changed while stalled");

    // Full is only reported with every slot in use
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |->
            rsp_fill_count == CNT_W'(STACK_DEPTH) && rsp_read_value == '0)
        else $error("full status with a count below depth or nonzero data");

    // Empty is only reported with no slot in use
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_EMPTY |->
            rsp_fill_count == '0 && rsp_read_value == '0)
        else $error("empty status with nonzero count or data");

    // Count never exceeds the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_fill_count <= CNT_W'(STACK_DEPTH))
        else $error("fill count beyond stack depth");

endmodule

bind stack_with_middle_ops smo_checker #(
    .STACK_DEPTH (STACK_DEPTH),
    .CNT_W       (CNT_W)
) u_smo_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_read_value (rsp.read_value),
    .rsp_status     (rsp.status),
    .rsp_fill_count (rsp.fill_count)
);

`default_nettype wire

@@ verif/stack_with_middle_ops_tb.sv @@
// ============================================================================
// stack_with_middle_ops_tb
// Self-checking bench for the stack with push, pop, peek and middle commands.
// A short table of directed commands (empty stack, one and two entries, the
// full stack, unused codes, extreme words) is followed by about two thousand
// random commands that fill and drain the stack towards moving targets. Each
// response transaction is checked field by field against a typed response or
// a mirror of the stack kept in the bench, while the command side sends in
// bursts and the response side stalls in phases of changing density.
// ============================================================================
`default_nettype none

module stack_with_middle_ops_tb
    import smo_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FILL_BITS    = $clog2(DEF_STACK_DEPTH + 1);
    localparam int RANDOM_ITEMS = 2000;
    localparam int SETTLE_TICKS = 4;

    // Mode codes that the block must ignore
    localparam logic [MODE_BITS-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_SPARE_7 = 3'd7;

    localparam logic [VALUE_BITS-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [VALUE_BITS-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_BITS-1:0] WORD_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] read_value;
        status_t                      status;
        logic [FILL_BITS-1:0]         fill_count;
    } response_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]  mode;
        logic [VALUE_BITS-1:0] value;
        logic [4:0]            reps;   // value advances by one per repeat
        logic                  fixed;  // use the typed response below
        response_t             want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 18;

    // Directed commands. Typed responses only where the answer is obvious;
    // everything else goes through the mirror.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // every read-type command on the empty stack
        '{MODE_POP,      '0,        5'd1,  1'b1, '{'0, ST_EMPTY, 5'd0}},
        '{MODE_PEEK,     '0,        5'd1,  1'b1, '{'0, ST_EMPTY, 5'd0}},
        '{MODE_FIND_MID, '0,        5'd1,  1'b1, '{'0, ST_EMPTY, 5'd0}},
        '{MODE_DEL_MID,  '0,        5'd1,  1'b1, '{'0, ST_EMPTY, 5'd0}},
        // unused code on the empty stack
        '{MODE_SPARE_5,  WORD_ONES, 5'd1,  1'b1, '{'0, ST_OK, 5'd0}},
        // pop of the last entry
        '{MODE_PUSH,     WORD_MIN,  5'd1,  1'b1, '{'0, ST_OK, 5'd1}},
        '{MODE_POP,      '0,        5'd1,  1'b1, '{WORD_MIN, ST_OK, 5'd0}},
        // delete middle with a single entry
        '{MODE_PUSH,     WORD_MAX,  5'd1,  1'b1, '{'0, ST_OK, 5'd1}},
        '{MODE_DEL_MID,  '0,        5'd1,  1'b1, '{WORD_MAX, ST_OK, 5'd0}},
        // delete middle with two entries removes the lower one
        '{MODE_PUSH,     WORD_MAX,  5'd1,  1'b1, '{'0, ST_OK, 5'd1}},
        '{MODE_PUSH,     WORD_MIN,  5'd1,  1'b1, '{'0, ST_OK, 5'd2}},
        '{MODE_DEL_MID,  '0,        5'd1,  1'b1, '{WORD_MAX, ST_OK, 5'd1}},
        // fill to the top, crossing the sign boundary on the way
        '{MODE_PUSH,     32'hFFFF_FFF9, 5'd15, 1'b0, '{'0, ST_OK, 5'd0}},
        // push on the full stack
        '{MODE_PUSH,     32'h5555_5555, 5'd1, 1'b1,
          '{'0, ST_FULL, FILL_BITS'(DEF_STACK_DEPTH)}},
        '{MODE_FIND_MID, '0,        5'd1,  1'b0, '{'0, ST_OK, 5'd0}},
        '{MODE_DEL_MID,  '0,        5'd1,  1'b0, '{'0, ST_OK, 5'd0}},
        '{MODE_SPARE_7,  WORD_MIN,  5'd1,  1'b0, '{'0, ST_OK, 5'd0}},
        '{MODE_PEEK,     '0,        5'd1,  1'b0, '{'0, ST_OK, 5'd0}}
    };

    logic clk;
    logic rst_n;

    smo_in_if  cmd_if ();
    smo_out_if #(.CNT_W(FILL_BITS)) rsp_if ();

    stack_with_middle_ops u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if.sink),
        .rsp   (rsp_if.source)
    );

    // Mirror of the stack: index 0 is the bottom
    logic [VALUE_BITS-1:0] stack_mirror [DEF_STACK_DEPTH];
    int unsigned           mirror_fill;

    // Responses still owed by the block, oldest first
    response_t   awaited_responses [$];
    int unsigned mismatch_count;
    int unsigned burst_left;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Hard stop in case the handshake locks up
    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // Advance the mirror by one command and return the response it implies
    function automatic response_t predict_stack_op(input logic [MODE_BITS-1:0] m,
                                                   input logic [VALUE_BITS-1:0] v);
        response_t   r;
        int unsigned mid;
        int unsigned i;
        r.read_value = '0;
        r.status     = ST_OK;
        case (m)
            MODE_PUSH:
            begin
                if (mirror_fill >= DEF_STACK_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    stack_mirror[mirror_fill] = v;
                    mirror_fill++;
                end
            end
            MODE_POP, MODE_PEEK:
            begin
                if (mirror_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.read_value = stack_mirror[mirror_fill - 1];
                    if (m == MODE_POP)
                        mirror_fill--;
                end
            end
            MODE_FIND_MID, MODE_DEL_MID:
            begin
                if (mirror_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    // middle counted from the bottom: ceil(count/2) - 1
                    mid = (mirror_fill + 1) / 2 - 1;
                    r.read_value = stack_mirror[mid];
                    if (m == MODE_DEL_MID)
                    begin
                        // close the gap: entries above the middle drop one place
                        for (i = mid; i + 1 < mirror_fill; i++)
                            stack_mirror[i] = stack_mirror[i + 1];
                        mirror_fill--;
                    end
                end
            end
            default: ;  // unused codes leave the stack alone
        endcase
        r.fill_count = FILL_BITS'(mirror_fill);
        return r;
    endfunction

    // Send one command transaction. Bursts of back-to-back transactions are
    // separated by random gaps; the mirror advances at the accepting edge.
    task automatic send_command(input logic [MODE_BITS-1:0]  m,
                                input logic [VALUE_BITS-1:0] v,
                                input logic                  use_fixed,
                                input response_t             fixed_want);
        response_t predicted;
        if (burst_left == 0)
        begin
            // drop valid and wiggle the payload while idle
            cmd_if.valid      <= 1'b0;
            cmd_if.mode       <= MODE_BITS'($urandom);
            cmd_if.push_value <= $urandom;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(1, 16);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.mode       <= m;
        cmd_if.push_value <= v;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        burst_left--;
        predicted = predict_stack_op(m, v);
        awaited_responses.push_back(use_fixed ? fixed_want : predicted);
    endtask

    // Hold the command side until every owed response has come back
    task automatic drain_responses();
        cmd_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_responses.size() != 0);
        burst_left = 0;
    endtask

    // Response side: check each transaction and stall in phases of varying
    // density, including phases with no stalls at all.
    initial
    begin : response_checker
        response_t   want;
        int unsigned stall_pct;
        int unsigned phase_left;
        rsp_if.ready <= 1'b0;
        stall_pct  = 0;
        phase_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    $display("%0t: unexpected response read_value %0d status %0d fill_count %0d",
                             $time, rsp_if.read_value, rsp_if.status, rsp_if.fill_count);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    if (rsp_if.read_value !== want.read_value)
                    begin
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.read_value, rsp_if.read_value);
                        mismatch_count++;
                    end
                    if (rsp_if.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp_if.status);
                        mismatch_count++;
                    end
                    if (rsp_if.fill_count !== want.fill_count)
                    begin
                        $display("%0t: fill_count expected %0d actual %0d",
                                 $time, want.fill_count, rsp_if.fill_count);
                        mismatch_count++;
                    end
                end
            end
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(16, 256);
                case ($urandom_range(3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            phase_left--;
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Stimulus: directed table, then random fill-and-drain traffic
    initial
    begin : stimulus
        response_t             no_fixed;
        logic [MODE_BITS-1:0]  m;
        logic [VALUE_BITS-1:0] v;
        int unsigned           random_sent;
        int unsigned           target_fill;
        int unsigned           target_left;
        int unsigned           pick;
        int unsigned           k;
        bit                    paused;

        no_fixed          = '{'0, ST_OK, '0};
        mirror_fill       = 0;
        mismatch_count    = 0;
        burst_left        = 0;
        random_sent       = 0;
        target_fill       = 0;
        target_left       = 0;
        paused            = 1'b0;
        rst_n             = 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.mode       <= MODE_PUSH;
        cmd_if.push_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[row])
        begin
            for (k = 0; k < DIRECTED[row].reps; k++)
                send_command(DIRECTED[row].mode, DIRECTED[row].value + k,
                             DIRECTED[row].fixed, DIRECTED[row].want);
        end
        drain_responses();

        // Random part: steer the fill towards a target that moves now and
        // then, favouring empty and full so the edge cases recur.
        while (random_sent < RANDOM_ITEMS)
        begin
            if (target_left == 0)
            begin
                target_left = $urandom_range(8, 60);
                case ($urandom_range(3))
                    0:       target_fill = 0;
                    1:       target_fill = DEF_STACK_DEPTH;
                    default: target_fill = $urandom_range(DEF_STACK_DEPTH);
                endcase
            end
            target_left--;

            pick = $urandom_range(99);
            if (pick < 3)
                m = MODE_BITS'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
            else if (mirror_fill < target_fill)
                m = (pick < 78) ? MODE_PUSH
                                : MODE_BITS'($urandom_range(MODE_POP, MODE_DEL_MID));
            else
                m = (pick < 23) ? MODE_PUSH
                                : MODE_BITS'($urandom_range(MODE_POP, MODE_DEL_MID));

            if ($urandom_range(7) == 0)
            begin
                case ($urandom_range(3))
                    0:       v = WORD_MIN;
                    1:       v = WORD_MAX;
                    2:       v = '0;
                    default: v = WORD_ONES;
                endcase
            end
            else
                v = $urandom;

            send_command(m, v, 1'b0, no_fixed);
            if (m <= MODE_DEL_MID)
                random_sent++;

            // one full pause half way through
            if (!paused && random_sent == RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                drain_responses();
            end
        end

        drain_responses();
        repeat (SETTLE_TICKS) @(posedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
